// ===== design/pbe_pkg.sv =====
// ----------------------------------------------------------------------------
// pbe_pkg
// Shared types and constants for the periodic budget enforcer.
// ----------------------------------------------------------------------------
package pbe_pkg;

  localparam int NUM_ENTRIES_DEF = 4;

  localparam int USED_W    = 40;
  localparam int ELAPSED_W = 16;
  localparam int CYCLES_W  = 32;
  localparam int ENTRY_W   = 2;
  localparam int MASK_W    = 4;

  localparam int ACTIVE_W  = 3;
  localparam int BUDGET_W  = 32;
  localparam int PERIOD_W  = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET_FIRST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET_REST    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS   = 2'd3;

  // request kinds
  localparam logic CMD_USAGE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST       = 3'd0;
  localparam logic [BUDGET_W-1:0] BUDGET_FIRST_RST = 32'd144000000;
  localparam logic [BUDGET_W-1:0] BUDGET_REST_RST  = 32'd72000000;
  localparam logic [PERIOD_W-1:0] PERIOD_RST       = 16'd20;

  typedef struct packed {
    logic [USED_W-1:0]    used;
    logic [ELAPSED_W-1:0] elapsed;
  } entry_word_t;

endpackage

// ===== design/pbe_ram.sv =====
// ----------------------------------------------------------------------------
// pbe_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module pbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/periodic_budget_enforcer_core.sv =====
// ----------------------------------------------------------------------------
// periodic_budget_enforcer_core
// Per-entry cycle budget accounting with periodic replenishment.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. Used and elapsed counts of all
// entries sit in one memory with a registered read; the sequencer reads an
// entry, updates it and writes it back, streaming the next read behind the
// write, so one entry is handled per cycle through its write and read port.
// A usage report passes ST_MOD then ST_DONE (an inactive entry goes straight
// to ST_DONE); a tick walks the active entries in ST_MOD. Input is taken
// again as soon as the result has moved into the output register. No clearing
// pass after reset: per-entry valid bits make unwritten entries read as zero.
module periodic_budget_enforcer_core
  import pbe_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // requests
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // entry[1:0], cycles[33:2], zero pad
  input  logic                  s_tuser,   // cmd
  // results
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // suspended_mask[3:0], zero pad
  output logic                  m_tuser    // bad_entry
);

  localparam int IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);
  localparam int WORD_W = $bits(entry_word_t);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // configuration registers
  logic [ACTIVE_W-1:0] active_entries;
  logic [BUDGET_W-1:0] budget_first;
  logic [BUDGET_W-1:0] budget_rest;
  logic [PERIOD_W-1:0] period_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= ACTIVE_RST;
      budget_first   <= BUDGET_FIRST_RST;
      budget_rest    <= BUDGET_REST_RST;
      period_ticks   <= PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_ENTRIES: active_entries <= cfg_data[ACTIVE_W-1:0];
        REG_BUDGET_FIRST:   budget_first   <= cfg_data[BUDGET_W-1:0];
        REG_BUDGET_REST:    budget_rest    <= cfg_data[BUDGET_W-1:0];
        REG_PERIOD_TICKS:   period_ticks   <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] live_n;
  always_comb begin
    if (32'(active_entries) > NUM_ENTRIES) begin
      live_n = CNT_W'(NUM_ENTRIES);
    end else begin
      live_n = CNT_W'(active_entries);
    end
  end

  // sequencer state
  logic [1:0]            state;
  logic [CNT_W-1:0]      cur_idx;
  logic                  is_tick;
  logic                  bad_q;
  logic [CYCLES_W-1:0]   cycles_q;
  logic                  rd_vld;
  logic [NUM_ENTRIES-1:0] vld;
  logic [NUM_ENTRIES-1:0] susp;
  logic [IDX_W-1:0]      rd_addr_q;

  logic [ENTRY_W-1:0]  in_entry;
  logic [CYCLES_W-1:0] in_cycles;
  logic                in_acc;
  logic                in_bad;
  logic                out_free;

  assign in_entry  = s_tdata[ENTRY_W-1:0];
  assign in_cycles = s_tdata[ENTRY_W +: CYCLES_W];
  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign in_bad    = (s_tuser == CMD_USAGE) && (32'(in_entry) >= 32'(live_n));
  assign out_free  = !m_tvalid || m_tready;

  // memory port control
  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_rdata;
  entry_word_t       rd_word;
  entry_word_t       wr_word;

  logic [CNT_W-1:0]  idx_inc;
  logic              last_entry;
  logic [USED_W-1:0] budget40;
  logic [USED_W:0]   sum;
  logic [ELAPSED_W-1:0] e_inc;
  logic              over;
  logic              repl;

  assign idx_inc    = cur_idx + CNT_W'(1);
  assign last_entry = (idx_inc == live_n);
  assign ram_waddr  = cur_idx[IDX_W-1:0];

  always_comb begin
    rd_word = rd_vld ? entry_word_t'(ram_rdata) : '0;
    budget40 = (cur_idx == '0) ? USED_W'(budget_first) : USED_W'(budget_rest);
    sum   = {1'b0, rd_word.used} + (USED_W + 1)'(cycles_q);
    e_inc = rd_word.elapsed + ELAPSED_W'(1);
    over  = rd_word.used > budget40;
    repl  = 32'(e_inc) >= 32'(period_ticks);

    wr_word = rd_word;
    if (is_tick) begin
      wr_word.used    = repl ? '0 : rd_word.used;
      wr_word.elapsed = repl ? '0 : e_inc;
    end else begin
      wr_word.used = sum[USED_W] ? '1 : sum[USED_W-1:0];
    end

    ram_we    = (state == ST_MOD);
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (in_acc && !in_bad) begin
      ram_re    = 1'b1;
      ram_raddr = (s_tuser == CMD_TICK) ? '0 : IDX_W'(in_entry);
    end else if (state == ST_MOD && is_tick && !last_entry) begin
      // next entry's read streams behind this write-back
      ram_re    = 1'b1;
      ram_raddr = idx_inc[IDX_W-1:0];
    end
  end

  pbe_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_word),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic [MASK_W-1:0] mask;
  always_comb begin
    mask = '0;
    for (int b = 0; b < MASK_W; b++) begin
      if (b < NUM_ENTRIES) begin
        mask[b] = susp[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vld    <= vld[ram_raddr];
      rd_addr_q <= ram_raddr;
    end
    if (in_acc) begin
      cycles_q <= in_cycles;
      is_tick  <= (s_tuser == CMD_TICK);
      bad_q    <= in_bad;
      cur_idx  <= (s_tuser == CMD_TICK) ? '0 : CNT_W'(in_entry);
    end else if (state == ST_MOD) begin
      cur_idx <= idx_inc;
    end
    if (state == ST_DONE && out_free) begin
      m_tdata <= OUT_DATA_W'(mask);
      m_tuser <= bad_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      vld      <= '0;
      susp     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_bad || (s_tuser == CMD_TICK && live_n == '0)) begin
              state <= ST_DONE;
            end else begin
              state <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          vld[ram_waddr] <= 1'b1;
          if (is_tick) begin
            // suspend on overrun, cleared by replenish or back within budget
            susp[ram_waddr] <= repl ? 1'b0 : over;
          end
          if (!is_tick || last_entry) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // tick walk stays inside the active entries
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD && is_tick) |-> (cur_idx < live_n))
    else $error("tick walk beyond active entries");

  // write-back goes to the entry that was just read
  a_wb_addr: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ram_waddr == rd_addr_q))
    else $error("write-back address differs from read address");

  // a tick never reports a bad entry
  a_tick_not_bad: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && is_tick) |-> !bad_q)
    else $error("bad entry flagged on tick");

  // usage to a valid entry always goes through the read-modify-write
  a_usage_path: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_tuser == CMD_USAGE && !in_bad) |=> (state == ST_MOD))
    else $error("usage report skipped memory update");

endmodule
